[rtl/reversible_circuit_evaluator_assert.svh]
// assertion macros for the reversible circuit evaluator
// clk and arst_n are taken from the module that uses the macros
`ifndef REVERSIBLE_CIRCUIT_EVALUATOR_ASSERT_SVH
`define REVERSIBLE_CIRCUIT_EVALUATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define RCE_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("rce: invariant violated");

// antecedent implies consequent in the same cycle
`define RCE_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rce: implication violated");

`else

`define RCE_ASSERT_ALWAYS(label, cond)

`define RCE_ASSERT_IMPLIES(label, ante, cons)

`endif

`endif

[rtl/rce_pkg.sv]
package rce_pkg;

	// fixed field widths
	localparam int KIND_W   = 1;
	localparam int INDEX_W  = 5;
	localparam int WORD_W   = 16;
	localparam int VEC_W    = 8;
	localparam int CNT_W    = 9;
	localparam int ACTIVE_W = 6;
	localparam int GC_W     = 6;
	localparam int LC_W     = 4;
	localparam int CFG_W    = 6;

	// lines carried by one gate word and the usable line limit
	localparam int WORD_LINES = 8;
	localparam int MAX_LINES  = 8;
	localparam int LINE_LIM   = (MAX_LINES < WORD_LINES) ? MAX_LINES : WORD_LINES;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
	localparam logic [KIND_W-1:0] KIND_EVAL = 1'b1;

	// per-line gate codes
	localparam logic [1:0] CODE_CTRL0     = 2'd0;
	localparam logic [1:0] CODE_CTRL1     = 2'd1;
	localparam logic [1:0] CODE_DONT_CARE = 2'd2;
	localparam logic [1:0] CODE_TARGET    = 2'd3;

	// configuration register indexes
	localparam logic REG_GATE_COUNT = 1'b0;
	localparam logic REG_LINE_COUNT = 1'b1;

	// saturation limit of the match counter
	localparam logic [CNT_W-1:0] COUNT_MAX = 9'd256;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] gate_index;
		logic [WORD_W-1:0]  gate_word;
		logic [VEC_W-1:0]   test_input;
		logic [VEC_W-1:0]   expected_output;
	} item_t;

	typedef struct packed {
		logic [VEC_W-1:0]    circuit_output;
		logic                matches_res;
		logic [CNT_W-1:0]    match_count;
		logic [ACTIVE_W-1:0] active_gates;
	} result_t;

	// word moving down the cell chain, lines indexed by line number
	typedef struct packed {
		logic               valid;
		logic [KIND_W-1:0]  kind;
		logic [VEC_W-1:0]   lines;
		logic [CNT_W-1:0]   cnt;
	} token_t;

endpackage

[rtl/rce_cell.sv]
module rce_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          wr_en,
	input  logic [rce_pkg::WORD_W-1:0]    wr_word,
	input  logic                          en,
	input  logic [rce_pkg::VEC_W-1:0]     lmask,
	input  rce_pkg::token_t               tok_in,
	output rce_pkg::token_t               tok_out
);
	import rce_pkg::*;

	logic [WORD_W-1:0] gate_q;
	logic              fire;
	logic [VEC_W-1:0]  tmask;
	token_t            nxt;
	token_t            tok_q;

	// gate word held by this cell
	always_ff @(posedge clk) begin
		if (wr_en) begin
			gate_q <= wr_word;
		end
	end

	// control match and last target line among lines in use
	always_comb begin
		logic [1:0] code;
		fire  = 1'b1;
		tmask = '0;
		code  = '0;
		for (int j = 0; j < WORD_LINES; j++) begin
			code = gate_q[2*j +: 2];
			if (lmask[j]) begin
				case (code) inside
					CODE_CTRL0, CODE_CTRL1: begin
						if (tok_in.lines[j] != code[0]) begin
							fire = 1'b0;
						end
					end
					CODE_TARGET: begin
						tmask = VEC_W'(1) << j;
					end
					default: ;
				endcase
			end
		end
	end

	// apply gate and count it when it holds a target
	always_comb begin
		nxt = tok_in;
		if (en) begin
			nxt.cnt = tok_in.cnt + CNT_W'(|tmask);
			if (tok_in.kind == KIND_EVAL && fire) begin
				nxt.lines = tok_in.lines ^ tmask;
			end
		end
	end

	// hand the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

[rtl/reversible_circuit_evaluator.sv]
// an item passes the head register, the gate cells and then the output register
// one item in flight: the item walks the gate cell chain one cell per cycle and
// the next item enters once the result is registered
// a waiting result does not block the next item from entering
// reset: async active low; clears the match counter, valid flags and the config
// registers (gate_count 4, line_count 3); gate words are undefined until loaded
`include "reversible_circuit_evaluator_assert.svh"

module reversible_circuit_evaluator #(
	parameter int MAX_GATES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  rce_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output rce_pkg::result_t            result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [rce_pkg::CFG_W-1:0]   cfg_data
);
	import rce_pkg::*;

	logic [GC_W-1:0]   gate_count_q;
	logic [LC_W-1:0]   line_count_q;
	logic [LC_W-1:0]   n_lines;
	logic [VEC_W-1:0]  lmask;
	logic [MAX_GATES-1:0] en;
	logic              accept;
	logic              busy_q;
	logic              adv;
	logic              xfer;
	token_t            head_q;
	token_t            chain [MAX_GATES+1];
	logic [MAX_GATES:0] tok_valid;
	logic [VEC_W-1:0]  entry_lines;
	logic [VEC_W-1:0]  exp_q;
	logic [VEC_W-1:0]  vec_out;
	logic              hit;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_next;
	logic              out_valid_q;
	result_t           out_q;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_count_q <= GC_W'(4);
			line_count_q <= LC_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GATE_COUNT: gate_count_q <= cfg_data;
				REG_LINE_COUNT: line_count_q <= cfg_data[LC_W-1:0];
				default: ;
			endcase
		end
	end

	// lines in use and gates applied
	assign n_lines = (int'(line_count_q) > LINE_LIM) ? LC_W'(LINE_LIM) : line_count_q;

	always_comb begin
		for (int j = 0; j < VEC_W; j++) begin
			lmask[j] = int'(n_lines) > j;
		end
		for (int g = 0; g < MAX_GATES; g++) begin
			en[g] = int'(gate_count_q) > g;
		end
	end

	// input handshake, one item in flight
	assign item_stall = busy_q;
	assign accept     = item_valid && !item_stall;

	// msb-first vector to line-indexed bits
	always_comb begin
		entry_lines = '0;
		for (int j = 0; j < VEC_W; j++) begin
			for (int p = 0; p < VEC_W; p++) begin
				if (j < int'(n_lines) && p == int'(n_lines) - 1 - j) begin
					entry_lines[j] = item.test_input[p];
				end
			end
		end
	end

	// head of the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (accept) begin
			head_q.valid <= 1'b1;
			head_q.kind  <= item.kind;
			head_q.lines <= entry_lines;
			head_q.cnt   <= '0;
		end else if (adv) begin
			head_q.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			exp_q <= item.expected_output;
		end
	end

	// chain of gate cells
	assign chain[0] = head_q;

	for (genvar g = 0; g < MAX_GATES; g++) begin : g_cell
		rce_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.wr_en   (accept && item.kind == KIND_LOAD && int'(item.gate_index) == g),
			.wr_word (item.gate_word),
			.en      (en[g]),
			.lmask   (lmask),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	always_comb begin
		for (int g = 0; g <= MAX_GATES; g++) begin
			tok_valid[g] = chain[g].valid;
		end
	end

	// chain end into the output register
	assign xfer = chain[MAX_GATES].valid && (!out_valid_q || !result_stall);
	assign adv  = !(chain[MAX_GATES].valid && !xfer);

	// line-indexed bits back to msb-first vector
	always_comb begin
		vec_out = '0;
		for (int p = 0; p < VEC_W; p++) begin
			for (int j = 0; j < VEC_W; j++) begin
				if (j < int'(n_lines) && p == int'(n_lines) - 1 - j) begin
					vec_out[p] = chain[MAX_GATES].lines[j];
				end
			end
		end
	end

	// match check and saturating counter, cleared by a load item
	always_comb begin
		hit      = (chain[MAX_GATES].kind == KIND_EVAL) && (vec_out == exp_q);
		cnt_next = cnt_q;
		if (chain[MAX_GATES].kind == KIND_LOAD) begin
			cnt_next = '0;
		end else if (hit && cnt_q != COUNT_MAX) begin
			cnt_next = cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (xfer) begin
				busy_q <= 1'b0;
			end
			if (xfer) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (xfer) begin
			out_q.circuit_output <= (chain[MAX_GATES].kind == KIND_EVAL) ? vec_out : '0;
			out_q.matches_res    <= hit;
			out_q.match_count    <= cnt_next;
			out_q.active_gates   <= chain[MAX_GATES].cnt[ACTIVE_W-1:0];
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// checks
	`RCE_ASSERT_ALWAYS(a_single_word_in_chain, $onehot0(tok_valid))
	`RCE_ASSERT_IMPLIES(a_idle_chain_empty, !busy_q, tok_valid == '0)
	`RCE_ASSERT_ALWAYS(a_counter_saturates, cnt_q <= COUNT_MAX)
	`RCE_ASSERT_IMPLIES(a_match_counted, result_valid && result.matches_res, result.match_count != '0)

endmodule
